@@ hdl/tailsitter_actuator_mixer_unit_assert.svh @@
// assertion macros for the actuator mixer checker
`ifndef TAILSITTER_ACTUATOR_MIXER_UNIT_ASSERT_SVH
`define TAILSITTER_ACTUATOR_MIXER_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define TAM_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("%m: check failed");
// next-cycle implication checked outside reset
`define TAM_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("%m: check failed");
`endif

@@ hdl/tam_pkg.sv @@
// shared types, constants and fixed-point helpers for the actuator mixer
`timescale 1ns / 1ps
package tam_pkg;
   localparam int CW = 31;
   localparam int QF = 16;
   localparam int NUM_REGS = 7;
   localparam int IDX_W = 3;
   localparam int DIV_PIPE = 49;
   localparam int SQRT_PIPE = 24;
   localparam logic signed [31:0] DEG_PER_RAD = 32'sd3754936;
   localparam logic [IDX_W-1:0] REG_LIFT   = 3'd0;
   localparam logic [IDX_W-1:0] REG_THRUST = 3'd1;
   localparam logic [IDX_W-1:0] REG_ARM    = 3'd2;
   localparam logic [IDX_W-1:0] REG_PITCH  = 3'd3;
   localparam logic [IDX_W-1:0] REG_YAW    = 3'd4;
   localparam logic [IDX_W-1:0] REG_MLIM   = 3'd5;
   localparam logic [IDX_W-1:0] REG_SLIM   = 3'd6;
   localparam logic signed [31:0] QMAX = 32'sh7fffffff;
   localparam logic signed [31:0] QMIN = 32'sh80000000;

   typedef struct packed {
      logic [CW-1:0] kl;
      logic [CW-1:0] kt;
      logic [CW-1:0] arm;
      logic [CW-1:0] kp;
      logic [CW-1:0] km;
      logic [CW-1:0] mlim;
      logic [CW-1:0] slim;
   } coeff_type;

   function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
      if (x > 64'sh7fffffff) sat64 = QMAX;
      else if (x < -64'sh80000000) sat64 = QMIN;
      else sat64 = x[31:0];
   endfunction

   // truncating q16 product of two 32 bit signed values
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] t;
      p = 64'(a) * 64'(b);
      t = (p < 0) ? -((-p) >>> QF) : (p >>> QF);
      qmul = sat64(t);
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      qadd = sat64(64'(a) + 64'(b));
   endfunction

   function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      qsub = sat64(64'(a) - 64'(b));
   endfunction

   function automatic logic signed [31:0] ucoef(input logic [CW-1:0] c);
      ucoef = signed'({1'b0, c});
   endfunction
endpackage

@@ hdl/tam_div.sv @@
// pipelined signed q16 divider, one quotient bit per stage
`timescale 1ns / 1ps
module tam_div #(
   parameter int SIDE_W = 1
) (
   input  logic clock,
   input  logic adv,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   input  logic [SIDE_W-1:0] side_in,
   output logic signed [31:0] quo,
   output logic zero_div,
   output logic [SIDE_W-1:0] side_out
);
   import tam_pkg::*;
   localparam int ST = DIV_PIPE;
   localparam int NB = DIV_PIPE - 1;

   logic [NB-1:0] rem_ff [ST];
   logic [NB-1:0] qt_ff [ST];
   logic [NB-1:0] dv_ff [ST];
   logic neg_ff [ST];
   logic zd_ff [ST];
   logic nneg_ff [ST];
   logic [SIDE_W-1:0] sd_ff [ST];
   logic [NB-1:0] n_abs;
   logic [NB-1:0] d_abs;
   logic [NB:0] mag;

   always_comb begin
      n_abs = (num < 0) ? NB'(-(64'(num))) << QF : NB'(64'(num)) << QF;
      d_abs = (den < 0) ? NB'(-(64'(den))) : NB'(64'(den));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= '0;
         qt_ff[0] <= n_abs;
         dv_ff[0] <= d_abs;
         neg_ff[0] <= (num < 0) ^ (den < 0);
         zd_ff[0] <= (den == 0);
         nneg_ff[0] <= (num < 0);
         sd_ff[0] <= side_in;
         for (int i = 1; i < ST; i++) begin
            logic [NB:0] tr;
            tr = {rem_ff[i-1], qt_ff[i-1][NB-1]};
            if (tr >= {1'b0, dv_ff[i-1]}) begin
               rem_ff[i] <= NB'(tr - {1'b0, dv_ff[i-1]});
               qt_ff[i] <= {qt_ff[i-1][NB-2:0], 1'b1};
            end else begin
               rem_ff[i] <= tr[NB-1:0];
               qt_ff[i] <= {qt_ff[i-1][NB-2:0], 1'b0};
            end
            dv_ff[i] <= dv_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            zd_ff[i] <= zd_ff[i-1];
            nneg_ff[i] <= nneg_ff[i-1];
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   always_comb begin
      mag = {1'b0, qt_ff[ST-1]};
      if (zd_ff[ST-1]) quo = nneg_ff[ST-1] ? QMIN : QMAX;
      else if (neg_ff[ST-1]) quo = sat64(-(64'(mag)));
      else quo = sat64(64'(mag));
      zero_div = zd_ff[ST-1];
      side_out = sd_ff[ST-1];
   end
endmodule

@@ hdl/tam_sqrt.sv @@
// pipelined integer square root of a 48 bit value, one result bit per stage
`timescale 1ns / 1ps
module tam_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic clock,
   input  logic adv,
   input  logic [47:0] val,
   input  logic [SIDE_W-1:0] side_in,
   output logic [23:0] root,
   output logic [SIDE_W-1:0] side_out
);
   import tam_pkg::*;
   localparam int ST = SQRT_PIPE + 1;

   logic [47:0] v_ff [ST];
   logic [49:0] r_ff [ST];
   logic [23:0] q_ff [ST];
   logic [SIDE_W-1:0] sd_ff [ST];

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff[0] <= val;
         r_ff[0] <= '0;
         q_ff[0] <= '0;
         sd_ff[0] <= side_in;
         for (int i = 1; i < ST; i++) begin
            logic [49:0] tr;
            logic [49:0] tt;
            tr = {r_ff[i-1][47:0], v_ff[i-1][47:46]};
            tt = {24'd0, q_ff[i-1], 2'b01};
            if (tr >= tt) begin
               r_ff[i] <= tr - tt;
               q_ff[i] <= {q_ff[i-1][22:0], 1'b1};
            end else begin
               r_ff[i] <= tr;
               q_ff[i] <= {q_ff[i-1][22:0], 1'b0};
            end
            v_ff[i] <= {v_ff[i-1][45:0], 2'b00};
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   assign root = q_ff[ST-1];
   assign side_out = sd_ff[ST-1];
endmodule

@@ hdl/tailsitter_actuator_mixer_unit.sv @@
// Actuator mixer for a two-rotor, two-servo tailsitter. One transfer in per clock
// while rsp_stall is low. A request passes through six product stages, a 49 stage
// radix-2 divider, one stage after the divide, a 25 stage square root and the
// output register. A stall on rsp freezes the whole pipeline; req_stall follows
// rsp_stall.
`timescale 1ns / 1ps
module tailsitter_actuator_mixer_unit (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [tam_pkg::IDX_W-1:0] csr_index,
   input  logic [tam_pkg::CW-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_thrust,
   input  logic signed [31:0] req_moment_x,
   input  logic signed [31:0] req_moment_y,
   input  logic signed [31:0] req_moment_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [30:0] rsp_motor_left,
   output logic [30:0] rsp_motor_right,
   output logic signed [31:0] rsp_servo_right,
   output logic signed [31:0] rsp_servo_left,
   output logic [1:0] rsp_negative_speed,
   output logic rsp_zero_divisor
);
   import tam_pkg::*;

   coeff_type cf_ff;
   logic adv;
   assign adv = !rsp_stall;
   assign req_stall = rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cf_ff.kl <= 31'd65536; cf_ff.kt <= 31'd65536; cf_ff.arm <= 31'd65536;
         cf_ff.kp <= 31'd65536; cf_ff.km <= 31'd65536; cf_ff.mlim <= 31'd65536;
         cf_ff.slim <= 31'd5898240;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LIFT:   cf_ff.kl <= csr_data;
            REG_THRUST: cf_ff.kt <= csr_data;
            REG_ARM:    cf_ff.arm <= csr_data;
            REG_PITCH:  cf_ff.kp <= csr_data;
            REG_YAW:    cf_ff.km <= csr_data;
            REG_MLIM:   cf_ff.mlim <= csr_data;
            REG_SLIM:   cf_ff.slim <= csr_data;
            default: ;
         endcase
      end
   end

   logic signed [31:0] kl, kt, ll, kp, km;
   assign kl = ucoef(cf_ff.kl);
   assign kt = ucoef(cf_ff.kt);
   assign ll = ucoef(cf_ff.arm);
   assign kp = ucoef(cf_ff.kp);
   assign km = ucoef(cf_ff.km);

   // product chain stages; stage one registers the request, stages two to six hold the multiplies
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [31:0] fa1_ff, mx1_ff, my1_ff, mz1_ff;
   logic signed [31:0] fal2_ff, den2_ff, klkt2_ff, kpkt2_ff, kmkp2_ff, klkp2_ff;
   logic signed [31:0] fa2x_ff, mx2_ff, my2_ff, mz2_ff;
   logic signed [31:0] tfl3_ff, den3_ff, a3_ff, b3_ff, c3_ff, kkl3_ff, d3_ff, mx3_ff;
   logic signed [31:0] sl4_ff, sr4_ff, den4_ff, a4_ff, b4_ff, c4_ff, dr4_ff, mxt4_ff;
   logic signed [31:0] d4_ff, e4_ff;
   logic signed [31:0] sl5_ff, sr5_ff, den5_ff, a5_ff, b5_ff, c5_ff, dr5_ff;
   logic signed [31:0] d5_ff, e5_ff;
   logic signed [31:0] sl6_ff, sr6_ff, den6_ff, nr6_ff, dn6_ff, nl6_ff, dl6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff; v5_ff <= v4_ff; v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fa1_ff <= req_thrust; mx1_ff <= req_moment_x;
         my1_ff <= req_moment_y; mz1_ff <= req_moment_z;
         // stage 2
         fal2_ff <= qmul(fa1_ff, ll);
         den2_ff <= qmul(kt, ll);
         klkt2_ff <= qmul(kl, kt);
         kpkt2_ff <= qmul(kp, kt);
         kmkp2_ff <= qmul(km, kp);
         klkp2_ff <= qmul(kl, kp);
         fa2x_ff <= qadd(fa1_ff, fa1_ff);
         mx2_ff <= mx1_ff; my2_ff <= my1_ff; mz2_ff <= mz1_ff;
         // stage 3
         tfl3_ff <= qadd(fal2_ff, fal2_ff);
         den3_ff <= qadd(den2_ff, den2_ff);
         a3_ff <= qmul(klkt2_ff, my2_ff);
         b3_ff <= qmul(kpkt2_ff, mz2_ff);
         c3_ff <= qmul(kmkp2_ff, kt);
         kkl3_ff <= qmul(klkp2_ff, ll);
         d3_ff <= qmul(fa2x_ff, kl);
         mx3_ff <= mx2_ff;
         // stage 4
         sl4_ff <= qadd(mx3_ff, tfl3_ff);
         sr4_ff <= qsub(tfl3_ff, mx3_ff);
         den4_ff <= den3_ff;
         a4_ff <= qmul(a3_ff, ll);
         b4_ff <= qmul(b3_ff, ll);
         c4_ff <= qmul(c3_ff, mx3_ff);
         dr4_ff <= kkl3_ff;
         mxt4_ff <= qsub(mx3_ff, tfl3_ff);
         d4_ff <= qmul(d3_ff, kp);
         e4_ff <= qmul(klkp2_ff, mx3_ff);
         // stage 5
         sl5_ff <= sl4_ff; sr5_ff <= sr4_ff; den5_ff <= den4_ff;
         a5_ff <= qmul(a4_ff, ll);
         b5_ff <= b4_ff; c5_ff <= c4_ff;
         dr5_ff <= qmul(dr4_ff, mxt4_ff);
         d5_ff <= qmul(d4_ff, ll);
         e5_ff <= qmul(e4_ff, ll);
         // stage 6
         sl6_ff <= sl5_ff; sr6_ff <= sr5_ff; den6_ff <= den5_ff;
         nr6_ff <= qadd(qsub(a5_ff, b5_ff), c5_ff);
         dn6_ff <= dr5_ff;
         nl6_ff <= qsub(32'sd0, qsub(qadd(a5_ff, b5_ff), c5_ff));
         dl6_ff <= qadd(qmul(d5_ff, ll), e5_ff);
      end
   end

   // four dividers: speed left, speed right, delta right, delta left
   logic signed [31:0] q_sl, q_sr, q_dr, q_dl;
   logic z_sl, z_sr, z_dr, z_dl;
   logic vd;
   tam_div #(.SIDE_W(1)) u_div_sl (.clock, .adv, .num(sl6_ff), .den(den6_ff),
      .side_in(v6_ff), .quo(q_sl), .zero_div(z_sl), .side_out(vd));
   tam_div #(.SIDE_W(1)) u_div_sr (.clock, .adv, .num(sr6_ff), .den(den6_ff),
      .side_in(1'b0), .quo(q_sr), .zero_div(z_sr), .side_out());
   tam_div #(.SIDE_W(1)) u_div_dr (.clock, .adv, .num(nr6_ff), .den(dn6_ff),
      .side_in(1'b0), .quo(q_dr), .zero_div(z_dr), .side_out());
   tam_div #(.SIDE_W(1)) u_div_dl (.clock, .adv, .num(nl6_ff), .den(dl6_ff),
      .side_in(1'b0), .quo(q_dl), .zero_div(z_dl), .side_out());

   // stage after divide: zero negatives, servo products
   logic vq_ff;
   logic [30:0] spl_ff, spr_ff;
   logic [1:0] neg_ff;
   logic zq_ff;
   logic signed [31:0] svr_ff, svl_ff;
   always_ff @(posedge clock) begin
      if (reset) vq_ff <= 1'b0;
      else if (adv) vq_ff <= vd;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         spl_ff <= (q_sl < 0) ? 31'd0 : q_sl[30:0];
         spr_ff <= (q_sr < 0) ? 31'd0 : q_sr[30:0];
         neg_ff <= {q_sr < 0, q_sl < 0};
         zq_ff <= z_sl | z_sr | z_dr | z_dl;
         svr_ff <= qmul(q_dr, DEG_PER_RAD);
         svl_ff <= qmul(q_dl, DEG_PER_RAD);
      end
   end

   localparam int SW = 2 + 1 + 64 + 1;
   logic [SW-1:0] sq_side_in, sq_side_out;
   logic [23:0] rt_l, rt_r;
   assign sq_side_in = {neg_ff, zq_ff, svr_ff, svl_ff, vq_ff};
   tam_sqrt #(.SIDE_W(SW)) u_sqrt_l (.clock, .adv, .val({1'b0, spl_ff, 16'd0}),
      .side_in(sq_side_in), .root(rt_l), .side_out(sq_side_out));
   tam_sqrt #(.SIDE_W(1)) u_sqrt_r (.clock, .adv, .val({1'b0, spr_ff, 16'd0}),
      .side_in(1'b0), .root(rt_r), .side_out());

   // divide root by 800 through reciprocal multiply, then clamp
   logic signed [31:0] sr_s, sl_s;
   logic [1:0] neg_s;
   logic z_s, v_s;
   assign {neg_s, z_s, sr_s, sl_s, v_s} = sq_side_out;
   logic [47:0] ml_p, mr_p;
   logic [23:0] dl_q, dr_q;
   // 2^34/800 rounded up is exact for 24 bit dividends
   assign ml_p = 48'(rt_l) * 48'd21474837;
   assign mr_p = 48'(rt_r) * 48'd21474837;
   assign dl_q = 24'(ml_p >> 34);
   assign dr_q = 24'(mr_p >> 34);

   logic signed [31:0] slim_pos, slim_neg;
   assign slim_pos = ucoef(cf_ff.slim);
   assign slim_neg = -slim_pos;

   logic rv_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (adv) rv_ff <= v_s;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_motor_left <= (31'(dl_q) > cf_ff.mlim) ? cf_ff.mlim : 31'(dl_q);
         rsp_motor_right <= (31'(dr_q) > cf_ff.mlim) ? cf_ff.mlim : 31'(dr_q);
         rsp_servo_right <= (sr_s > slim_pos) ? slim_pos :
                            (sr_s < slim_neg) ? slim_neg : sr_s;
         rsp_servo_left <= (sl_s > slim_pos) ? slim_pos :
                           (sl_s < slim_neg) ? slim_neg : sl_s;
         rsp_negative_speed <= neg_s;
         rsp_zero_divisor <= z_s;
      end
   end
   assign rsp_valid = rv_ff;
endmodule

@@ hdl/tam_checker.sv @@
// port-level checker for the actuator mixer, bound to the top level
`timescale 1ns / 1ps
`include "tailsitter_actuator_mixer_unit_assert.svh"
module tam_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [30:0] rsp_motor_left,
   input logic [30:0] rsp_motor_right
);
   `TAM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `TAM_ASSERT_IMP(a_stall_link, clock, reset, rsp_stall, req_stall)
   `TAM_ASSERT_NEXT(a_data_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_motor_left) && $stable(rsp_motor_right))
endmodule

bind tailsitter_actuator_mixer_unit tam_checker u_tam_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_motor_left, .rsp_motor_right
);
